// ----- design/tx_ring_buffer_block_dispatch_assert.svh -----
// Assertion macros shared by the ring buffer modules.
`ifndef TX_RING_BUFFER_BLOCK_DISPATCH_ASSERT_SVH
`define TX_RING_BUFFER_BLOCK_DISPATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TXRB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TXRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/txrb_pkg.sv -----
`default_nettype none

package txrb_pkg;

   localparam int DEPTH  = 256;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int SIZE_W = IDX_W + 1;
   localparam int BYTE_W = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);

   typedef enum logic [1:0] {
      FN_WRITE = 2'd0,
      FN_DONE  = 2'd1,
      FN_READ  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_COUNT = 2'd2,
      ST_PASS      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [BYTE_W-1:0] data_byte;
      logic [7:0]        sent_count;
      logic [IDX_W-1:0]  read_index;
      logic              tx_busy;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic              req_valid;
      logic [IDX_W-1:0]  req_start;
      logic [7:0]        req_len;
      logic [BYTE_W-1:0] pass_byte;
      logic              is_read;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } ram_write_type;

   // Length of the contiguous run of queued bytes starting at the tail.
   function automatic logic [SIZE_W-1:0] used_len(
      input logic [IDX_W-1:0]  head,
      input logic [IDX_W-1:0]  tail,
      input logic [SIZE_W-1:0] size
   );
      logic [SIZE_W-1:0] len;
      if (tail > head) begin
         len = size - {1'b0, tail};
      end else begin
         len = {1'b0, head} - {1'b0, tail};
      end
      return len;
   endfunction

   function automatic logic [7:0] sat_len(input logic [SIZE_W-1:0] len);
      logic [7:0] res;
      if (len > SIZE_W'(255)) begin
         res = 8'hFF;
      end else begin
         res = len[7:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- design/txrb_req_if.sv -----
`default_nettype none

interface txrb_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic [txrb_pkg::BYTE_W-1:0]    data_byte;
   logic [7:0]                     sent_count;
   logic [txrb_pkg::IDX_W-1:0]     read_index;
   logic                           tx_busy;

   modport source (
      output valid, func, data_byte, sent_count, read_index, tx_busy,
      input  ready
   );
   modport sink (
      input  valid, func, data_byte, sent_count, read_index, tx_busy,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/txrb_rsp_if.sv -----
`default_nettype none

interface txrb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic                           req_valid;
   logic [txrb_pkg::IDX_W-1:0]     req_start;
   logic [7:0]                     req_len;
   logic [txrb_pkg::BYTE_W-1:0]    read_data;
   logic [txrb_pkg::BYTE_W-1:0]    pass_byte;

   modport source (
      output valid, status, req_valid, req_start, req_len, read_data, pass_byte,
      input  ready
   );
   modport sink (
      input  valid, status, req_valid, req_start, req_len, read_data, pass_byte,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/txrb_ram.sv -----
`default_nettype none

module txrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/txrb_ctrl.sv -----
`default_nettype none
`include "tx_ring_buffer_block_dispatch_assert.svh"

module txrb_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [txrb_pkg::SIZE_W-1:0]      csr_data,
   input  wire logic                             accept,
   input  wire txrb_pkg::item_type               item,
   output txrb_pkg::result_type                  result,
   output txrb_pkg::ram_write_type               ram_wr
);

   logic [txrb_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [txrb_pkg::IDX_W-1:0]  tail_ff, tail_in;
   logic [txrb_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [txrb_pkg::SIZE_W-1:0] size_ring;
   logic [txrb_pkg::SIZE_W-1:0] next_head;
   logic [txrb_pkg::SIZE_W-1:0] next_tail;
   logic [txrb_pkg::SIZE_W-1:0] cur_len;
   logic [txrb_pkg::SIZE_W-1:0] req_len;

   assign size_ring = (size_ff > txrb_pkg::SIZE_MAX) ? txrb_pkg::SIZE_MAX : size_ff;

   always_comb begin
      result    = '0;
      result.status = txrb_pkg::ST_OK;
      ram_wr    = '0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      size_in   = size_ff;
      req_len   = '0;
      cur_len   = txrb_pkg::used_len(head_ff, tail_ff, size_ring);
      next_head = {1'b0, head_ff} + txrb_pkg::SIZE_W'(1);
      if (next_head >= size_ring) begin
         next_head = '0;
      end
      next_tail = {1'b0, tail_ff} + {1'b0, item.sent_count};
      if (next_tail >= size_ring) begin
         next_tail = '0;
      end
      if (csr_we) begin
         size_in = csr_data;
         head_in = '0;
         tail_in = '0;
      end else if (accept) begin
         case (item.func)
            txrb_pkg::FN_WRITE: begin
               if (size_ring == '0) begin
                  result.status    = txrb_pkg::ST_PASS;
                  result.pass_byte = item.data_byte;
               end else begin
                  if (next_head == {1'b0, tail_ff}) begin
                     result.status = txrb_pkg::ST_FULL;
                  end else begin
                     ram_wr.we   = 1'b1;
                     ram_wr.addr = head_ff;
                     ram_wr.data = item.data_byte;
                     head_in     = next_head[txrb_pkg::IDX_W-1:0];
                  end
                  if (!item.tx_busy) begin
                     req_len          = txrb_pkg::used_len(head_in, tail_ff, size_ring);
                     result.req_valid = (req_len != '0);
                     result.req_start = result.req_valid ? tail_ff : '0;
                     result.req_len   = txrb_pkg::sat_len(req_len);
                  end
               end
            end
            txrb_pkg::FN_DONE: begin
               if (size_ring != '0) begin
                  if ({1'b0, item.sent_count} > cur_len) begin
                     result.status = txrb_pkg::ST_BAD_COUNT;
                  end else begin
                     tail_in          = next_tail[txrb_pkg::IDX_W-1:0];
                     req_len          = txrb_pkg::used_len(head_ff, tail_in, size_ring);
                     result.req_valid = (req_len != '0);
                     result.req_start = result.req_valid ? tail_in : '0;
                     result.req_len   = txrb_pkg::sat_len(req_len);
                  end
               end
            end
            txrb_pkg::FN_READ: begin
               result.is_read = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         size_ff <= txrb_pkg::SIZE_RESET;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         size_ff <= size_in;
      end
   end

   `TXRB_ASSERT_SAME(a_ptr_in_ring, clock, reset, size_ring != '0,
      ({1'b0, head_ff} < size_ring) && ({1'b0, tail_ff} < size_ring),
      "ring pointer outside the ring")
   `TXRB_ASSERT_NEXT(a_bad_count_keeps_tail, clock, reset,
      accept && !csr_we && (result.status == txrb_pkg::ST_BAD_COUNT),
      $stable(tail_ff), "tail moved on a bad completion count")

endmodule

`default_nettype wire

// ----- design/tx_ring_buffer_block_dispatch.sv -----
// Channel  | Direction | Carries
// req_chan | in        | func, data_byte, sent_count, read_index, tx_busy
// rsp_chan | out       | status, req_valid, req_start, req_len, read_data, pass_byte
// csr      | in        | buffer_size write (csr_wr_en, csr_wr_data)
//
// Each transaction produces one result in the cycle after it is accepted.
// A new transaction is accepted every cycle while the result register is empty or being taken.
// The byte store is a single RAM with one write and one registered read per cycle.
// Reset is synchronous; it empties the ring and sets buffer_size to 256.
// A stalled result holds in the output register and blocks further input.
`default_nettype none
`include "tx_ring_buffer_block_dispatch_assert.svh"

module tx_ring_buffer_block_dispatch (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [txrb_pkg::SIZE_W-1:0] csr_wr_data,
   txrb_req_if.sink                         req_chan,
   txrb_rsp_if.source                       rsp_chan
);

   logic                          accept;
   logic                          rsp_valid_ff;
   txrb_pkg::result_type          res_ff;
   txrb_pkg::result_type          result;
   txrb_pkg::ram_write_type       ram_wr;
   txrb_pkg::item_type            item;
   logic [txrb_pkg::BYTE_W-1:0]   ram_q;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign item.func       = req_chan.func;
   assign item.data_byte  = req_chan.data_byte;
   assign item.sent_count = req_chan.sent_count;
   assign item.read_index = req_chan.read_index;
   assign item.tx_busy    = req_chan.tx_busy;

   txrb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_wr_en),
      .csr_data (csr_wr_data),
      .accept   (accept),
      .item     (item),
      .result   (result),
      .ram_wr   (ram_wr)
   );

   txrb_ram #(
      .WIDTH (txrb_pkg::BYTE_W),
      .DEPTH (txrb_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .re    (accept && (req_chan.func == txrb_pkg::FN_READ)),
      .raddr (req_chan.read_index),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= accept;
      end
      if (accept) begin
         res_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = res_ff.status;
   assign rsp_chan.req_valid = res_ff.req_valid;
   assign rsp_chan.req_start = res_ff.req_start;
   assign rsp_chan.req_len   = res_ff.req_len;
   assign rsp_chan.pass_byte = res_ff.pass_byte;
   assign rsp_chan.read_data = res_ff.is_read ? ram_q : '0;

   `TXRB_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff,
      "accepted transaction produced no result")

endmodule

`default_nettype wire

// ----- sim/tx_ring_buffer_block_dispatch_checker.sv -----
`default_nettype none

module tx_ring_buffer_block_dispatch_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [txrb_pkg::SIZE_W-1:0] csr_wr_data,
   txrb_req_if                              req_mon,
   txrb_rsp_if                              rsp_mon,
   output int                               fail_count,
   output int                               outstanding,
   output logic [txrb_pkg::DEPTH-1:0]       stored_mask,
   output int                               run_len
);
   import txrb_pkg::*;

   typedef struct packed {
      status_type status;
      logic       req_valid;
      logic [7:0] req_start;
      logic [7:0] req_len;
      logic [7:0] read_data;
      logic [7:0] pass_byte;
   } ring_outcome;

   logic [7:0]  ring_mem [0:DEPTH-1];
   int unsigned head_pos;
   int unsigned tail_pos;
   int unsigned size_cfg;
   ring_outcome pending_outcomes [$];
   ring_outcome want;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      stored_mask = '0;
      run_len     = 0;
   end

   function automatic int unsigned ring_len();
      return (size_cfg > DEPTH) ? DEPTH : size_cfg;
   endfunction

   function automatic int unsigned contiguous_run(input int unsigned size);
      if (tail_pos > head_pos) begin
         return size - tail_pos;
      end
      return head_pos - tail_pos;
   endfunction

   function automatic void offer_block(input int unsigned size, inout ring_outcome o);
      int unsigned len;
      len = contiguous_run(size);
      if (len != 0) begin
         o.req_valid = 1'b1;
         o.req_start = 8'(tail_pos);
         o.req_len   = (len > 255) ? 8'hFF : 8'(len);
      end
   endfunction

   function automatic ring_outcome ring_step(
      input logic [1:0] func,
      input logic [7:0] data,
      input logic [7:0] count,
      input logic [7:0] ridx,
      input logic       busy
   );
      ring_outcome o;
      int unsigned size;
      int unsigned nxt;
      o        = '0;
      o.status = ST_OK;
      size     = ring_len();
      case (func)
         FN_WRITE: begin
            if (size == 0) begin
               o.status    = ST_PASS;
               o.pass_byte = data;
            end else begin
               nxt = head_pos + 1;
               if (nxt >= size) begin
                  nxt = 0;
               end
               if (nxt == tail_pos) begin
                  o.status = ST_FULL;
               end else begin
                  ring_mem[head_pos]    = data;
                  stored_mask[head_pos] = 1'b1;
                  head_pos              = nxt;
               end
               if (!busy) begin
                  offer_block(size, o);
               end
            end
         end
         FN_DONE: begin
            if (size != 0) begin
               if (count > contiguous_run(size)) begin
                  o.status = ST_BAD_COUNT;
               end else begin
                  nxt = tail_pos + count;
                  if (nxt >= size) begin
                     nxt = 0;
                  end
                  tail_pos = nxt;
                  offer_block(size, o);
               end
            end
         end
         FN_READ: begin
            o.read_data = ring_mem[ridx];
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] expv,
                                       input logic [7:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_pos = 0;
         tail_pos = 0;
         size_cfg = DEPTH;
         pending_outcomes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_mon.status);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_mon.status));
               check_field("req_valid", 8'(want.req_valid), 8'(rsp_mon.req_valid));
               check_field("req_start", want.req_start, 8'(rsp_mon.req_start));
               check_field("req_len", want.req_len, rsp_mon.req_len);
               check_field("read_data", want.read_data, rsp_mon.read_data);
               check_field("pass_byte", want.pass_byte, rsp_mon.pass_byte);
            end
         end
         if (csr_wr_en) begin
            size_cfg = csr_wr_data;
            head_pos = 0;
            tail_pos = 0;
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_outcomes.push_back(ring_step(req_mon.func, req_mon.data_byte,
                                                 req_mon.sent_count, req_mon.read_index,
                                                 req_mon.tx_busy));
         end
      end
      outstanding = pending_outcomes.size();
      run_len     = contiguous_run(ring_len());
   end

endmodule

`default_nettype wire

// ----- sim/tx_ring_buffer_block_dispatch_tb.sv -----
`default_nettype none

module tx_ring_buffer_block_dispatch_tb;
   import txrb_pkg::*;

   localparam logic [1:0] FN_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   logic              idle_on;
   int                ready_hold;
   int                cycles;
   int                fail_count;
   int                outstanding;
   int                run_len;
   logic [DEPTH-1:0]  stored_mask;

   txrb_req_if req_if ();
   txrb_rsp_if rsp_if ();

   tx_ring_buffer_block_dispatch DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   tx_ring_buffer_block_dispatch_checker ring_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .stored_mask (stored_mask),
      .run_len     (run_len)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         ready_hold = $urandom_range(0, 2);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [7:0] data,
                            input logic [7:0] count, input logic [7:0] ridx,
                            input logic busy);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= func;
      req_if.data_byte  <= data;
      req_if.sent_count <= count;
      req_if.read_index <= ridx;
      req_if.tx_busy    <= busy;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_ring_size(input logic [SIZE_W-1:0] value);
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_read_index();
      int idx;
      repeat (64) begin
         idx = $urandom_range(0, DEPTH - 1);
         if (stored_mask[idx]) begin
            return 8'(idx);
         end
      end
      for (idx = 0; idx < DEPTH; idx++) begin
         if (stored_mask[idx]) begin
            return 8'(idx);
         end
      end
      return 8'd0;
   endfunction

   // Completions mostly retire part of the current run so that the ring keeps
   // draining and the head wraps; the rest are arbitrary counts.
   task automatic run_random(input int n_items, input int write_pct);
      int         roll;
      int         k;
      logic [7:0] count;
      for (k = 0; k < n_items; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < write_pct) begin
            send_item(FN_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
         end else if (roll < write_pct + 25) begin
            if ($urandom_range(0, 3) != 0) begin
               count = 8'($urandom_range(0, run_len));
            end else begin
               count = 8'($urandom);
            end
            send_item(FN_DONE, 8'($urandom), count, 8'($urandom),
                      1'($urandom_range(0, 1)));
         end else if (roll < write_pct + 40 && stored_mask != '0) begin
            send_item(FN_READ, 8'($urandom), 8'($urandom), pick_read_index(),
                      1'($urandom_range(0, 1)));
         end else if (roll < write_pct + 43) begin
            send_item(FN_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
         end else begin
            send_item(FN_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      idle_on           = 1'b1;
      ready_hold        = 0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.func       = FN_WRITE;
      req_if.data_byte  = '0;
      req_if.sent_count = '0;
      req_if.read_index = '0;
      req_if.tx_busy    = 1'b0;
      rsp_if.ready      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(FN_WRITE, 8'h00, 8'h00, 8'h00, 1'b1);
      send_item(FN_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_item(FN_WRITE, 8'hA5, 8'h00, 8'h00, 1'b0);
      send_item(FN_READ, 8'h00, 8'h00, 8'd0, 1'b0);
      send_item(FN_READ, 8'h00, 8'h00, 8'd1, 1'b0);
      send_item(FN_READ, 8'hFF, 8'hFF, 8'd2, 1'b1);
      send_item(FN_DONE, 8'h00, 8'd0, 8'h00, 1'b1);
      send_item(FN_DONE, 8'h00, 8'd200, 8'h00, 1'b0);
      send_item(FN_DONE, 8'h00, 8'd3, 8'h00, 1'b0);
      send_item(FN_DONE, 8'h00, 8'd0, 8'h00, 1'b0);
      send_item(FN_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);

      set_ring_size(9'd0);
      send_item(FN_WRITE, 8'h5A, 8'h00, 8'h00, 1'b0);
      send_item(FN_WRITE, 8'hFF, 8'h00, 8'h00, 1'b1);
      send_item(FN_DONE, 8'h00, 8'd5, 8'h00, 1'b0);
      send_item(FN_READ, 8'h00, 8'h00, 8'd1, 1'b0);

      set_ring_size(9'd1);
      send_item(FN_WRITE, 8'h11, 8'h00, 8'h00, 1'b0);
      send_item(FN_WRITE, 8'h12, 8'h00, 8'h00, 1'b1);

      set_ring_size(9'd2);
      send_item(FN_WRITE, 8'h22, 8'h00, 8'h00, 1'b1);
      send_item(FN_WRITE, 8'h33, 8'h00, 8'h00, 1'b0);
      send_item(FN_DONE, 8'h00, 8'd1, 8'h00, 1'b1);
      send_item(FN_WRITE, 8'h44, 8'h00, 8'h00, 1'b0);

      set_ring_size(9'd256);
      run_random(500, 55);
      set_ring_size(9'd0);
      run_random(100, 45);
      set_ring_size(9'd1);
      run_random(100, 45);
      set_ring_size(9'd2);
      run_random(150, 45);
      set_ring_size(9'd3);
      run_random(150, 45);
      set_ring_size(9'd17);
      run_random(200, 50);
      set_ring_size(9'd511);
      run_random(500, 55);
      set_ring_size(9'd255);
      run_random(300, 55);
      set_ring_size(9'($urandom_range(4, 300)));
      idle_on = 1'b0;
      run_random(200, 50);

      req_if.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
